// ===== design/svp_pkg.sv =====
// ----------------------------------------------------------------------------
// svp_pkg
// shared widths, item kinds, register indexes and parameter defaults of the
// sample playback voice
// ----------------------------------------------------------------------------
`default_nettype none

package svp_pkg;

  localparam int KIND_W     = 2;
  localparam int ADDR_IN_W  = 16;
  localparam int IN_SMP_W   = 16;
  localparam int PITCH_W    = 19;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 16;
  localparam int FCOUNT_W   = 17;
  localparam int POS_W      = 32;
  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 56;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam int DEF_FRAME_DEPTH = 65536;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FRAC_BITS   = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE    = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ONE_SHOT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEREO_SOURCE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT   = 2'd3;

endpackage

`default_nettype wire

// ===== design/svp_ram.sv =====
// ----------------------------------------------------------------------------
// svp_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module svp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sample_playback_voice.sv =====
// ----------------------------------------------------------------------------
// sample_playback_voice
// one voice of a linear interpolating stereo sample player
// ----------------------------------------------------------------------------
// Beats on the slave stream carry a kind in tuser: frame write, note on, note
// off or output tick; every beat gives exactly one result beat on the master
// stream. Items are handled one at a time and s_axis_tready is high only while
// the sequencer waits for a beat. A frame write passes through the states
// S_WMOD, S_WSUB and S_WWR when FRAME_DEPTH is not a power of two and below
// 65536, for the address remainder by reciprocal multiplication. A tick on a
// silent voice or at the end of the sample goes from S_TCHK straight to the
// result; a sounding tick makes two reads on the single read port of the frame
// memory and uses the one shared multiplier, which forms the interpolation and
// gain products of the left channel and, for a stereo source, of the right
// channel in turn. The result sits in an output register, so a beat is
// accepted while the previous result waits; the sequencer stalls only when a
// new result is ready and the old one is still not taken. The frame memory is
// not cleared: frames must be written before they are played.

`default_nettype none

module sample_playback_voice #(
  parameter int FRAME_DEPTH = svp_pkg::DEF_FRAME_DEPTH,
  parameter int SAMPLE_BITS = svp_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = svp_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // slave stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // frame_address, left_in, right_in, pitch_step, velocity_gain, zero pad
  input  wire logic [svp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // kind
  input  wire logic [svp_pkg::KIND_W-1:0]        s_axis_tuser,
  // master stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_left, out_right, out_mono, voice_active, zero pad
  output logic      [svp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [svp_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [svp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [svp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int AW     = $clog2(FRAME_DEPTH);
  localparam int IW     = svp_pkg::POS_W - FRAC_BITS;
  localparam int CW     = (IW + 1 > svp_pkg::FCOUNT_W) ? IW + 1 : svp_pkg::FCOUNT_W;
  localparam int NMAX   = (FRAME_DEPTH < 65536) ? FRAME_DEPTH : 65536;
  localparam bit POW2   = (FRAME_DEPTH & (FRAME_DEPTH - 1)) == 0;
  localparam bit WRAP   = (FRAME_DEPTH < (1 << svp_pkg::ADDR_IN_W)) && !POW2;
  localparam int MA     = SAMPLE_BITS + 1;
  localparam int MB     = ((FRAC_BITS > svp_pkg::GAIN_W) ? FRAC_BITS : svp_pkg::GAIN_W) + 1;
  localparam int PW     = MA + MB;
  localparam int GW     = SAMPLE_BITS + 2;
  localparam int RQ_S   = svp_pkg::ADDR_IN_W + AW;
  localparam int RQ_W   = 2 * svp_pkg::ADDR_IN_W + 1;
  localparam longint RQ_M = ((longint'(1) << RQ_S) + longint'(FRAME_DEPTH) - 1) /
                            longint'(FRAME_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_WMOD, S_WSUB, S_WWR, S_TCHK, S_RD1, S_RD2,
    S_MDL, S_MGL, S_MDR, S_MGR, S_MFR, S_DONE
  } state_t;

  state_t state;

  // input fields
  logic [svp_pkg::ADDR_IN_W-1:0] in_addr;
  logic signed [svp_pkg::IN_SMP_W-1:0] in_left, in_right;
  logic [svp_pkg::PITCH_W-1:0] in_pitch;
  logic [svp_pkg::GAIN_W-1:0] in_gain;
  svp_pkg::kind_t in_kind;
  logic accept;

  assign in_addr  = s_axis_tdata[15:0];
  assign in_left  = s_axis_tdata[31:16];
  assign in_right = s_axis_tdata[47:32];
  assign in_pitch = s_axis_tdata[66:48];
  assign in_gain  = s_axis_tdata[82:67];
  assign in_kind  = svp_pkg::kind_t'(s_axis_tuser);

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // configuration
  logic loop_enable, one_shot, stereo_source;
  logic [svp_pkg::FCOUNT_W-1:0] frame_count;
  logic cfg_wr;
  logic [svp_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable   <= 1'b0;
      one_shot      <= 1'b0;
      stereo_source <= 1'b0;
      frame_count   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        svp_pkg::REG_LOOP_ENABLE:   loop_enable   <= pwdata[0];
        svp_pkg::REG_ONE_SHOT:      one_shot      <= pwdata[0];
        svp_pkg::REG_STEREO_SOURCE: stereo_source <= pwdata[0];
        svp_pkg::REG_FRAME_COUNT:   frame_count   <= pwdata[svp_pkg::FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      svp_pkg::REG_LOOP_ENABLE:   prdata = 32'(loop_enable);
      svp_pkg::REG_ONE_SHOT:      prdata = 32'(one_shot);
      svp_pkg::REG_STEREO_SOURCE: prdata = 32'(stereo_source);
      svp_pkg::REG_FRAME_COUNT:   prdata = 32'(frame_count);
      default:                    prdata = '0;
    endcase
  end

  // voice state
  logic [svp_pkg::POS_W-1:0] pos;
  logic [svp_pkg::PITCH_W-1:0] step;
  logic [svp_pkg::GAIN_W-1:0] gain;
  logic is_active, is_held;

  logic [svp_pkg::FCOUNT_W-1:0] n_frames;
  logic [IW-1:0] idx;
  logic at_end;

  assign n_frames = (frame_count > svp_pkg::FCOUNT_W'(NMAX)) ?
                    svp_pkg::FCOUNT_W'(NMAX) : frame_count;
  assign idx      = pos[svp_pkg::POS_W-1:FRAC_BITS];
  assign at_end   = (CW'(idx) + CW'(1)) >= CW'(n_frames);

  // working registers
  logic [AW-1:0] rd_idx;
  logic [FRAC_BITS-1:0] frac_r;
  logic signed [SAMPLE_BITS-1:0] s0l, s0r, s1l, s1r, wl, wr;
  logic signed [PW-1:0] prod;
  logic signed [GW-1:0] res_l, res_r;
  logic [AW-1:0] rem;
  logic [svp_pkg::ADDR_IN_W-1:0] waddr_r, wquot;

  // address remainder by reciprocal multiplication
  logic [RQ_W-1:0] wprod;
  logic [svp_pkg::ADDR_IN_W-1:0] wrem;

  assign wprod = RQ_W'(waddr_r) * RQ_W'(RQ_M);
  assign wrem  = waddr_r - svp_pkg::ADDR_IN_W'(wquot * svp_pkg::ADDR_IN_W'(FRAME_DEPTH));

  // frame memory, right channel above left
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  assign ram_we    = (accept && in_kind == svp_pkg::KIND_WRITE && !WRAP) || (state == S_WWR);
  assign ram_waddr = (state == S_WWR) ? rem : AW'(in_addr);
  assign ram_wdata = (state == S_WWR) ? {wr, wl} :
                     {SAMPLE_BITS'(in_right), SAMPLE_BITS'(in_left)};
  assign ram_raddr = (state == S_TCHK) ? AW'(idx) : rd_idx + AW'(1);

  svp_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (FRAME_DEPTH)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier
  logic signed [PW-1:0] sh_frac, sh_gain, mul_out;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;

  assign sh_frac = prod >>> FRAC_BITS;
  assign sh_gain = prod >>> svp_pkg::GAIN_W;

  always_comb begin
    case (state)
      S_MDL: begin
        mul_a = MA'(s1l) - MA'(s0l);
        mul_b = MB'(frac_r);
      end
      S_MGL: begin
        mul_a = MA'(s0l) + sh_frac[MA-1:0];
        mul_b = MB'(gain);
      end
      S_MDR: begin
        mul_a = MA'(s1r) - MA'(s0r);
        mul_b = MB'(frac_r);
      end
      S_MGR: begin
        mul_a = MA'(s0r) + sh_frac[MA-1:0];
        mul_b = MB'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // output formatting
  function automatic logic [svp_pkg::OUT_W-1:0] sat16(input logic signed [31:0] x);
    logic signed [31:0] y;
    y = x;
    if (y > 32'sd32767) y = 32'sd32767;
    if (y < -32'sd32768) y = -32'sd32768;
    return y[svp_pkg::OUT_W-1:0];
  endfunction

  logic signed [GW:0] mono_sum, mono_sh;

  assign mono_sum = (GW + 1)'(res_l) + (GW + 1)'(res_r);
  assign mono_sh  = mono_sum >>> 1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      step          <= '0;
      gain          <= '0;
      is_active     <= 1'b0;
      is_held       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_l <= '0;
            res_r <= '0;
            state <= S_DONE;
            case (in_kind)
              svp_pkg::KIND_WRITE: begin
                wl      <= SAMPLE_BITS'(in_left);
                wr      <= SAMPLE_BITS'(in_right);
                waddr_r <= in_addr;
                if (WRAP) state <= S_WMOD;
              end
              svp_pkg::KIND_NOTE_ON: begin
                if (n_frames != '0) begin
                  step      <= in_pitch;
                  gain      <= in_gain;
                  pos       <= '0;
                  is_active <= 1'b1;
                  is_held   <= 1'b1;
                end
              end
              svp_pkg::KIND_NOTE_OFF: begin
                is_held <= 1'b0;
                if (!one_shot) is_active <= 1'b0;
              end
              svp_pkg::KIND_TICK: begin
                state <= S_TCHK;
              end
              default: ;
            endcase
          end
        end
        S_WMOD: begin
          wquot <= svp_pkg::ADDR_IN_W'(wprod >> RQ_S);
          state <= S_WSUB;
        end
        S_WSUB: begin
          rem   <= AW'(wrem);
          state <= S_WWR;
        end
        S_WWR: begin
          state <= S_DONE;
        end
        S_TCHK: begin
          if (!is_active) begin
            state <= S_DONE;
          end else if (at_end) begin
            if (loop_enable && is_held) pos <= '0;
            else is_active <= 1'b0;
            state <= S_DONE;
          end else begin
            rd_idx <= AW'(idx);
            frac_r <= pos[FRAC_BITS-1:0];
            pos    <= pos + svp_pkg::POS_W'(step);
            state  <= S_RD1;
          end
        end
        S_RD1: begin
          s0l   <= ram_rdata[SAMPLE_BITS-1:0];
          s0r   <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
          state <= S_RD2;
        end
        S_RD2: begin
          s1l   <= ram_rdata[SAMPLE_BITS-1:0];
          s1r   <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
          state <= S_MDL;
        end
        S_MDL: begin
          prod  <= mul_out;
          state <= S_MGL;
        end
        S_MGL: begin
          prod  <= mul_out;
          state <= S_MDR;
        end
        S_MDR: begin
          res_l <= sh_gain[GW-1:0];
          if (stereo_source) begin
            prod  <= mul_out;
            state <= S_MGR;
          end else begin
            res_r <= sh_gain[GW-1:0];
            state <= S_DONE;
          end
        end
        S_MGR: begin
          prod  <= mul_out;
          state <= S_MFR;
        end
        S_MFR: begin
          res_r <= sh_gain[GW-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, is_active, sat16(32'(mono_sh)),
                              sat16(32'(res_r)), sat16(32'(res_l))};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a beat is taken only when the sequencer is back from the previous one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("beat accepted while an item is in progress");

  // a silent voice delivers silence
  a_silent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[47:0] == '0)
    else $error("sound delivered on an inactive voice");

  // the position moves only for a note on or a playing voice
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !is_active && !accept |=> pos == $past(pos))
    else $error("position moved on an idle voice");

endmodule

`default_nettype wire
